// ===== design/ers_pkg.sv =====
// ers_pkg: shared constants, types and state encoding of the extreme row subset selector
// depends on nothing; imported by every design file
`default_nettype none
package ers_pkg;
  localparam int unsigned MaxRows     = 1024;
  localparam int unsigned MaxFeatures = 8;
  localparam int unsigned MaxSubset   = 64;
  localparam int unsigned StoreDepth  = MaxRows * MaxFeatures;
  localparam int unsigned RowW   = $clog2(MaxRows);
  localparam int unsigned FeatW  = (MaxFeatures > 1) ? $clog2(MaxFeatures) : 1;
  localparam int unsigned AddrW  = $clog2(StoreDepth);
  localparam int unsigned CntW   = $clog2(MaxSubset + 1);

  // register indexes
  localparam logic [1:0] RegRowCount     = 2'd0;
  localparam logic [1:0] RegFeatureCount = 2'd1;
  localparam logic [1:0] RegSubsetSize   = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD, ST_CLEAR, ST_SCAN, ST_DRAIN, ST_EMIT
  } ers_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_start;   // start clearing selection marks
    logic clear_step;    // clear one mark
    logic scan_start;    // begin a scan of one column
    logic scan_step;     // issue one store read
    logic commit;        // mark best row and register result
    logic end_run;       // reset load position
  } ers_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic issue_done;    // all rows issued
    logic pipe_empty;    // no read in flight
  } ers_stat_t;
endpackage
`default_nettype wire

// ===== design/ers_ctrl.sv =====
// ers_ctrl: sequencer of load, mark clear, column scans and result transfer
// depends on ers_pkg
`default_nettype none
module ers_ctrl
  import ers_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               last_i,
  output logic                    in_stall_o,
  input  wire logic [10:0]        row_cfg_i,
  input  wire logic [3:0]         feat_cfg_i,
  input  wire logic [6:0]         subset_cfg_i,
  input  wire ers_stat_t          stat_i,
  output ers_cmd_t                cmd_o,
  output logic [RowW:0]           n_o,
  output logic [FeatW:0]          p_o,
  output logic [FeatW-1:0]        col_o,
  output logic                    top_o,
  output logic                    out_valid_o,
  output logic                    out_last_o,
  input  wire logic               out_stall_i
);
  ers_state_e state_q, state_d;
  logic [RowW:0]    n_q, n_d;
  logic [FeatW:0]   p_q, p_d;
  logic [CntW-1:0]  r_q, r_d, u_q, u_d, taken_q, taken_d, grp_q, grp_d;
  logic [FeatW-1:0] col_q, col_d;
  logic             top_q, top_d, last_q, last_d;

  // saturated configuration and derived limits
  logic [RowW:0]   n_c;
  logic [FeatW:0]  p_c;
  logic [CntW-1:0] k_c, r_c, u_c;
  logic [CntW+FeatW+1:0] two_p, pr2;
  always_comb begin
    n_c = (row_cfg_i > 11'(MaxRows)) ? (RowW+1)'(MaxRows) : (RowW+1)'(row_cfg_i);
    p_c = (feat_cfg_i > 4'(MaxFeatures)) ? (FeatW+1)'(MaxFeatures) : (FeatW+1)'(feat_cfg_i);
    k_c = (subset_cfg_i > 7'(MaxSubset)) ? CntW'(MaxSubset) : CntW'(subset_cfg_i);
    if ((RowW+1)'(k_c) > n_c) k_c = CntW'(n_c);
    two_p = {(CntW+FeatW+1)'(p_c), 1'b0};
    // small quotient: r is at most MaxSubset/2, found by compare per candidate
    r_c = '0;
    for (int i = 1; i <= MaxSubset / 2; i++) begin
      if ((CntW+FeatW+2)'(i) * two_p <= (CntW+FeatW+2)'(k_c)) r_c = CntW'(i);
    end
    if (r_c == '0) r_c = CntW'(1);
    pr2 = (CntW+FeatW+2)'(two_p * (CntW+FeatW+2)'(r_c));
    u_c = (pr2 > (CntW+FeatW+2)'(k_c)) ? k_c : CntW'(pr2);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_valid_i && last_i) state_d = ST_CLEAR;
      ST_CLEAR: if (stat_i.clear_done) begin
        state_d = (n_q == '0 || p_q == '0 || u_q == '0) ? ST_LOAD : ST_SCAN;
      end
      ST_SCAN:  if (stat_i.issue_done) state_d = ST_DRAIN;
      ST_DRAIN: if (stat_i.pipe_empty) state_d = ST_EMIT;
      ST_EMIT:  if (!out_stall_i) state_d = last_q ? ST_LOAD : ST_SCAN;
      default:  state_d = ST_LOAD;
    endcase
  end

  // outputs and run bookkeeping
  always_comb begin
    cmd_o = '0;
    n_d = n_q; p_d = p_q; r_d = r_q; u_d = u_q;
    taken_d = taken_q; grp_d = grp_q; col_d = col_q; top_d = top_q; last_d = last_q;
    in_stall_o  = (state_q != ST_LOAD);
    out_valid_o = (state_q == ST_EMIT);
    unique case (state_q)
      ST_LOAD: if (in_valid_i && last_i) begin
        cmd_o.clear_start = 1'b1;
        n_d = n_c; p_d = p_c; r_d = r_c; u_d = u_c;
        taken_d = '0; grp_d = '0; col_d = '0; top_d = 1'b1;
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) begin
          cmd_o.scan_start = 1'b1;
          if (n_q == '0 || p_q == '0 || u_q == '0) cmd_o.end_run = 1'b1;
        end
      end
      ST_SCAN:  cmd_o.scan_step = 1'b1;
      ST_DRAIN: begin
        if (stat_i.pipe_empty) begin
          cmd_o.commit = 1'b1;
          last_d = (taken_q + CntW'(1) == u_q);
        end
      end
      ST_EMIT: if (!out_stall_i) begin
        taken_d = taken_q + CntW'(1);
        if (last_q) begin
          cmd_o.end_run = 1'b1;
        end else begin
          cmd_o.scan_start = 1'b1;
          if (grp_q + CntW'(1) == r_q) begin
            grp_d = '0;
            top_d = ~top_q;
            if (!top_q) col_d = col_q + FeatW'(1);
          end else begin
            grp_d = grp_q + CntW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // column and direction for the next scan follow the bookkeeping
  assign col_o      = (state_q == ST_EMIT) ? col_d : col_q;
  assign top_o      = (state_q == ST_EMIT) ? top_d : top_q;
  assign n_o        = n_q;
  assign p_o        = p_q;
  assign out_last_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      n_q <= '0; p_q <= '0; r_q <= '0; u_q <= '0;
      taken_q <= '0; grp_q <= '0; col_q <= '0; top_q <= 1'b1; last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q <= n_d; p_q <= p_d; r_q <= r_d; u_q <= u_d;
      taken_q <= taken_d; grp_q <= grp_d; col_q <= col_d; top_q <= top_d;
      last_q <= last_d;
    end
  end

  // assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> in_stall_o) else $error("input taken while busy");
  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (taken_q < u_q)) else $error("too many results");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_stall_i) |=> (state_q == ST_EMIT))
    else $error("stalled result dropped");
endmodule
`default_nettype wire

// ===== design/ers_dp.sv =====
// ers_dp: sample memory, selection marks and the pipelined column scan
// depends on ers_pkg
`default_nettype none
module ers_dp
  import ers_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [31:0]      sample_i,
  input  wire ers_cmd_t         cmd_i,
  input  wire logic [RowW:0]    n_i,
  input  wire logic [FeatW:0]   p_i,
  input  wire logic [FeatW-1:0] col_i,
  input  wire logic             top_i,
  output ers_stat_t             stat_o,
  output logic [RowW-1:0]       best_row_o
);
  logic [31:0]      store_q [StoreDepth];
  logic             mark_q  [MaxRows];
  logic [AddrW-1:0] load_q;
  logic [RowW:0]    clr_q, row_q;
  logic [AddrW-1:0] addr_q;
  logic [31:0]      rd_q;
  logic             mk_q;
  logic [RowW-1:0]  s1_row_q, best_q;
  logic             s1_v_q, s2_v_q, found_q;
  logic [31:0]      best_key_q;
  logic [31:0]      key;
  logic             better;

  // sample memory: load writes, scan reads registered
  always_ff @(posedge clk_i) begin
    if (wr_en_i) store_q[load_q] <= sample_i;
    rd_q <= store_q[addr_q];
  end

  // load position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) load_q <= '0;
    else if (cmd_i.end_run) load_q <= '0;
    else if (wr_en_i) load_q <= load_q + AddrW'(1);
  end

  // selection marks in a memory: cleared by a sweep, read one per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) mark_q[clr_q[RowW-1:0]] <= 1'b0;
    else if (cmd_i.commit) mark_q[best_q] <= 1'b1;
    mk_q <= mark_q[row_q[RowW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear_start) clr_q <= '0;
    else if (cmd_i.clear_step && !stat_o.clear_done) clr_q <= clr_q + (RowW+1)'(1);
  end
  assign stat_o.clear_done = (clr_q == (RowW+1)'(MaxRows - 1));

  // scan address generator: address row*p+col kept by adding p
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; addr_q <= '0; s1_v_q <= 1'b0; s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
      if (cmd_i.scan_start) begin
        row_q <= '0; addr_q <= AddrW'(col_i); s1_v_q <= 1'b0;
      end else if (cmd_i.scan_step && !stat_o.issue_done) begin
        row_q  <= row_q + (RowW+1)'(1);
        addr_q <= addr_q + AddrW'(p_i);
        s1_v_q <= 1'b1;
      end else begin
        s1_v_q <= 1'b0;
      end
    end
  end
  assign stat_o.issue_done = (row_q == n_i) || (row_q == (RowW+1)'(MaxRows));
  assign stat_o.pipe_empty = !s1_v_q && !s2_v_q;

  // row tag follows the registered read
  always_ff @(posedge clk_i) begin
    s1_row_q <= row_q[RowW-1:0];
  end

  // running best with strict compare, ties to the lower row
  assign key    = rd_q ^ 32'h8000_0000;
  assign better = !found_q || (top_i ? (key > best_key_q) : (key < best_key_q));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) found_q <= 1'b0;
    else if (cmd_i.scan_start) found_q <= 1'b0;
    else if (s1_v_q && !mk_q) found_q <= 1'b1;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) best_q <= '0;
    else if (s1_v_q && !mk_q && better) begin
      best_q <= s1_row_q; best_key_q <= key;
    end
  end
  assign best_row_o = best_q;

  // assertions
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (s1_row_q < n_i[RowW-1:0] || n_i == (RowW+1)'(MaxRows)))
    else $error("scan past row count");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clear_step && cmd_i.commit)) else $error("clear and commit together");
  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> stat_o.pipe_empty) else $error("commit with read in flight");
endmodule
`default_nettype wire

// ===== design/extreme_row_subset_selector.sv =====
// Extreme row subset selector: samples are loaded one per cycle while the block is idle.
// The item with last_sample set starts the selection: first all MaxRows (1024) selection
// marks are cleared, then each selected row costs one full column scan of the n rows, with
// n the saturated row count, through the sample memory's single read port, followed by its
// result transfer, which waits while the output is stalled. When nothing is selected, the
// run ends after the clear; no input is taken until the run has ended.
// depends on ers_pkg, ers_ctrl, ers_dp
`default_nettype none
module extreme_row_subset_selector
  import ers_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic signed [31:0] sample_value_i,
  input  wire logic        last_sample_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       row_index_o,
  output logic [2:0]       feature_index_o,
  output logic             from_top_o,
  output logic             last_result_o
);
  logic [10:0] row_cfg_q;
  logic [3:0]  feat_cfg_q;
  logic [6:0]  subset_cfg_q;
  ers_cmd_t    cmd;
  ers_stat_t   stat;
  logic [RowW:0]    n;
  logic [FeatW:0]   p;
  logic [FeatW-1:0] col, res_col_q;
  logic             top, res_top_q;
  logic [RowW-1:0]  best_row;
  logic             wr_en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q <= 11'd1024; feat_cfg_q <= 4'd8; subset_cfg_q <= 7'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRowCount:     row_cfg_q    <= cfg_data_i;
        RegFeatureCount: feat_cfg_q   <= cfg_data_i[3:0];
        RegSubsetSize:   subset_cfg_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign wr_en = in_valid_i && !in_stall_o;

  ers_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .last_i(last_sample_i), .in_stall_o,
    .row_cfg_i(row_cfg_q), .feat_cfg_i(feat_cfg_q), .subset_cfg_i(subset_cfg_q),
    .stat_i(stat), .cmd_o(cmd), .n_o(n), .p_o(p), .col_o(col), .top_o(top),
    .out_valid_o, .out_last_o(last_result_o), .out_stall_i
  );

  ers_dp u_dp (
    .clk_i, .rst_ni, .wr_en_i(wr_en), .sample_i(sample_value_i), .cmd_i(cmd),
    .n_i(n), .p_i(p), .col_i(col), .top_i(top), .stat_o(stat), .best_row_o(best_row)
  );

  // result tags captured with the commit
  always_ff @(posedge clk_i) begin
    if (cmd.commit) begin
      res_col_q <= col; res_top_q <= top;
    end
  end

  assign row_index_o     = best_row;
  assign feature_index_o = 3'(res_col_q);
  assign from_top_o      = res_top_q;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench of extreme_row_subset_selector, with its own predictor
// of the extreme row selection, a table of directed matrices and random runs
// depends on ers_pkg and the extreme_row_subset_selector rtl
`timescale 1ns / 1ps
module tb;
  import ers_pkg::*;

  localparam logic [1:0] RegUnused   = 2'd3;
  localparam int         DrainCycles = 1200;
  localparam int         CycleLimit  = 1_000_000;
  localparam int         RandomItems = 60;

  typedef struct packed {
    logic [9:0] row;
    logic [2:0] feat;
    logic       top;
    logic       last;
  } pick_t;

  typedef struct {
    logic [31:0] value;
    bit          last;
    int          n_typed;
    logic [9:0]  row0;
    bit          top0;
    logic [9:0]  row1;
    bit          top1;
  } plan_row_t;

  typedef struct {
    int rows;
    int feats;
    int subset;
    int runs;
  } setting_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic signed [31:0] sample_value_i = '0;
  logic        last_sample_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  row_index_o;
  logic [2:0]  feature_index_o;
  logic        from_top_o;
  logic        last_result_o;

  extreme_row_subset_selector DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .sample_value_i, .last_sample_i,
    .out_valid_o, .out_stall_i, .row_index_o, .feature_index_o,
    .from_top_o, .last_result_o
  );

  // predictor state
  logic [31:0] shadow_store [StoreDepth];
  bit          written [StoreDepth];
  int unsigned fill_pos;
  logic [10:0] rows_reg = 11'd1024;
  logic [3:0]  feats_reg = 4'd8;
  logic [6:0]  subset_reg = 7'd16;
  pick_t       fresh_picks [$];
  pick_t       picks_due [$];

  int  errors = 0;
  int  cycles = 0;
  int  sent_count = 0;
  bit  calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // append one expected result to a queue
  function automatic void add_pick(ref pick_t q[$], input pick_t item);
    q.insert(q.size(), item);
  endfunction

  // effective sizes after saturation and clipping
  task automatic sizes(output int unsigned n, output int unsigned p, output int unsigned k);
    n = (rows_reg > MaxRows) ? MaxRows : rows_reg;
    p = (feats_reg > MaxFeatures) ? MaxFeatures : feats_reg;
    k = (subset_reg > MaxSubset) ? MaxSubset : subset_reg;
    if (k > n) k = n;
  endtask

  // store one sample; on the last one work out the selected rows
  task automatic predict_selection(input logic [31:0] v, input bit last);
    int unsigned n, p, k, r, u, taken, cnt, best;
    logic [31:0] key, best_key;
    bit found;
    bit chosen [MaxRows];
    shadow_store[fill_pos] = v;
    written[fill_pos] = 1'b1;
    fill_pos = (fill_pos + 1) % StoreDepth;
    if (!last) return;
    sizes(n, p, k);
    if (n != 0 && p != 0 && k != 0) begin
      r = k / (2 * p);
      if (r == 0) r = 1;
      u = 2 * p * r;
      if (u > k) u = k;
      taken = 0;
      for (int j = 0; j < p && taken < u; j++) begin
        for (int ph = 0; ph < 2 && taken < u; ph++) begin
          cnt = u - taken;
          if (cnt > r) cnt = r;
          for (int t = 0; t < cnt; t++) begin
            found = 1'b0;
            best = 0;
            best_key = '0;
            // strict compare in ascending order leaves ties with the lower row
            for (int i = 0; i < n; i++) begin
              if (!chosen[i]) begin
                key = shadow_store[(i * p + j) % StoreDepth] ^ 32'h8000_0000;
                if (!found || (ph == 0 ? key > best_key : key < best_key)) begin
                  best = i;
                  best_key = key;
                  found = 1'b1;
                end
              end
            end
            chosen[best] = 1'b1;
            add_pick(fresh_picks, '{best[9:0], j[2:0], ph == 0, 1'b0});
            taken++;
          end
        end
      end
      if (fresh_picks.size() > 0) fresh_picks[fresh_picks.size() - 1].last = 1'b1;
    end
    fill_pos = 0;
  endtask

  // one sample transfer, with random gaps before it
  task automatic send_sample(input logic [31:0] v, input bit last, input bit use_model);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_value_i <= v;
    last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
    predict_selection(v, last);
    if (use_model) foreach (fresh_picks[i]) add_pick(picks_due, fresh_picks[i]);
    fresh_picks.delete();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegRowCount:     rows_reg = data;
      RegFeatureCount: feats_reg = data[3:0];
      RegSubsetSize:   subset_reg = data[6:0];
      default: ;
    endcase
  endtask

  // block idle: nothing owed and no run left that gives no result
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_setting(input int rows, input int feats, input int subset);
    wait_idle();
    write_reg(RegRowCount, rows[10:0]);
    write_reg(RegFeatureCount, feats[10:0]);
    write_reg(RegSubsetSize, subset[10:0]);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // one matrix load ending in a selection: mostly whole, some padded, some short
  task automatic load_matrix();
    int unsigned n, p, k, whole, len, mode;
    bit prefix_ok;
    sizes(n, p, k);
    whole = (n * p == 0) ? $urandom_range(1, 4) : n * p;
    len = whole;
    mode = $urandom_range(99);
    if (mode >= 70 && mode < 85) begin
      len = whole + $urandom_range(1, 3);
    end else if (mode >= 85 && whole > 1) begin
      prefix_ok = 1'b1;
      for (int i = 0; i < whole; i++) if (!written[i]) prefix_ok = 1'b0;
      if (prefix_ok) len = $urandom_range(1, whole - 1);
    end
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1, 1'b1);
  endtask

  // monitor and receiver stall
  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (picks_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result row %0d", row_index_o));
        end else begin
          want = picks_due.pop_front();
          if (row_index_o !== want.row)
            report_mismatch($sformatf("row_index %0d, want %0d", row_index_o, want.row));
          if (feature_index_o !== want.feat)
            report_mismatch($sformatf("feature_index %0d, want %0d", feature_index_o,
                                      want.feat));
          if (from_top_o !== want.top)
            report_mismatch($sformatf("from_top %0b, want %0b", from_top_o, want.top));
          if (last_result_o !== want.last)
            report_mismatch($sformatf("last_result %0b, want %0b", last_result_o, want.last));
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 35);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  plan_row_t plan [12] = '{
    '{32'h7FFF_FFFF, 1'b0, 0, 10'd0, 1'b0, 10'd0, 1'b0},
    '{32'h8000_0000, 1'b1, 2, 10'd0, 1'b1, 10'd1, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 0, 10'd0, 1'b0, 10'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 2, 10'd0, 1'b1, 10'd1, 1'b0},
    '{32'h8000_0000, 1'b0, 0, 10'd0, 1'b0, 10'd0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 2, 10'd1, 1'b1, 10'd0, 1'b0},
    '{32'h0000_0000, 1'b0, 0, 10'd0, 1'b0, 10'd0, 1'b0},
    '{32'h0001_0000, 1'b1, 2, 10'd1, 1'b1, 10'd0, 1'b0},
    '{32'h1234_5678, 1'b1, 0, 10'd0, 1'b0, 10'd0, 1'b0},
    '{32'h5555_5555, 1'b0, 0, 10'd0, 1'b0, 10'd0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 0, 10'd0, 1'b0, 10'd0, 1'b0},
    '{32'h0000_0000, 1'b1, 0, 10'd0, 1'b0, 10'd0, 1'b0}
  };

  setting_t settings [7] = '{
    '{3, 2, 5, 2},
    '{0, 3, 4, 1},
    '{4, 0, 4, 1},
    '{5, 2, 0, 1},
    '{4, 15, 127, 1},
    '{64, 1, 64, 1},
    '{12, 2, 17, 1}
  };

  initial begin
    int start;
    fill_pos = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: two rows, one feature, two picks
    write_reg(RegUnused, 11'h7FF);
    apply_setting(2, 1, 2);
    foreach (plan[i]) begin
      send_sample(plan[i].value, plan[i].last, plan[i].n_typed == 0);
      if (plan[i].n_typed != 0) begin
        add_pick(picks_due, '{plan[i].row0, 3'd0, plan[i].top0, 1'b0});
        add_pick(picks_due, '{plan[i].row1, 3'd0, plan[i].top1, 1'b1});
      end
    end

    // fixed settings, extremes and zero sizes among them; the full subset runs unpaused
    foreach (settings[s]) begin
      apply_setting(settings[s].rows, settings[s].feats, settings[s].subset);
      calm = (s == 5);
      for (int r = 0; r < settings[s].runs; r++) load_matrix();
      calm = 1'b0;
    end

    // random settings with small matrices
    start = sent_count;
    while (sent_count - start < RandomItems) begin
      apply_setting(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8),
                    ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 15),
                    $urandom_range(0, 127));
      repeat ($urandom_range(1, 2)) load_matrix();
    end

    wait_idle();
    if (picks_due.size() != 0) report_mismatch("results still owed at the end");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/ers_pkg.sv
design/ers_ctrl.sv
design/ers_dp.sv
design/extreme_row_subset_selector.sv
tb/tb.sv
